@@ design/hrc_pkg.sv @@
// ----------------------------------------------------------------------------
// hrc_pkg
// Shared widths, parameter defaults, register indexes, reset values and the
// gate code for the hysteresis-gated ramped crossfade.
// ----------------------------------------------------------------------------
package hrc_pkg;

    // Fixed field widths
    localparam int IN_W       = 32;
    localparam int OFFSET_W   = 31;
    localparam int STEP_W     = 16;
    localparam int GATE_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Parameter defaults
    localparam int DEF_VALUE_WIDTH      = 32;
    localparam int DEF_FACTOR_FRAC_BITS = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_OFFSET    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_DOWN_STEP = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_UP_STEP   = 8'd3;

    // Configuration reset values
    localparam logic [OFFSET_W-1:0] RST_HIGH_OFFSET    = 31'd655360000;
    localparam logic [OFFSET_W-1:0] RST_BAND_WIDTH     = 31'd6553600;
    localparam logic [STEP_W-1:0]   RST_RAMP_DOWN_STEP = 16'd1638;
    localparam logic [STEP_W-1:0]   RST_RAMP_UP_STEP   = 16'd32768;

    // Gate code that allows the factor to ramp down
    localparam logic [GATE_W-1:0] GATE_RAMP_DOWN = 8'd1;

endpackage

@@ design/hysteresis_ramped_crossfade.sv @@
// ----------------------------------------------------------------------------
// hysteresis_ramped_crossfade
// Hysteresis-gated Q1.15 blend factor and saturated Q16.16 crossfade.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input transaction passes through the input register,
// the product register and the result register before its result is valid.
// Throughput: one transaction per cycle; the pipeline stalls as a whole only
// while a result is held on the output.
// Reset: synchronous, active low; clears valids, flag and factor, and loads
// the configuration reset values.
module hysteresis_ramped_crossfade #(
    parameter int VALUE_WIDTH      = hrc_pkg::DEF_VALUE_WIDTH,
    parameter int FACTOR_FRAC_BITS = hrc_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [hrc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [hrc_pkg::CFG_DATA_W-1:0] cfg_data,
    // input transaction
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_sample,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_threshold_base,
    input  logic        [hrc_pkg::GATE_W-1:0]   s_gate_byte,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_term_a,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_term_b,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_term_c,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_target_term,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_add_term,
    input  logic signed [hrc_pkg::IN_W-1:0]     s_sub_term,
    // result transaction
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_WIDTH-1:0]       m_blended_value,
    output logic        [FACTOR_FRAC_BITS:0]    m_blend_factor_out,
    output logic                                m_hysteresis_flag,
    output logic        [hrc_pkg::GATE_W-1:0]   m_gate_echo
);

    localparam int FW = FACTOR_FRAC_BITS + 1;
    localparam logic [FW-1:0] FACTOR_ONE = FW'(1) << FACTOR_FRAC_BITS;

    // configuration registers
    logic [hrc_pkg::OFFSET_W-1:0] high_offset_reg;
    logic [hrc_pkg::OFFSET_W-1:0] band_width_reg;
    logic [hrc_pkg::STEP_W-1:0]   ramp_down_step_reg;
    logic [hrc_pkg::STEP_W-1:0]   ramp_up_step_reg;

    // pipeline control
    logic en;
    logic in_valid_reg;
    logic mid_valid_reg;
    logic out_valid_reg;

    // input register
    logic signed [hrc_pkg::IN_W-1:0]   sample_reg;
    logic signed [hrc_pkg::IN_W-1:0]   base_reg;
    logic        [hrc_pkg::GATE_W-1:0] gate_reg;
    logic signed [hrc_pkg::IN_W-1:0]   term_a_reg;
    logic signed [hrc_pkg::IN_W-1:0]   term_b_reg;
    logic signed [hrc_pkg::IN_W-1:0]   term_c_reg;
    logic signed [hrc_pkg::IN_W-1:0]   target_reg;
    logic signed [hrc_pkg::IN_W-1:0]   add_reg;
    logic signed [hrc_pkg::IN_W-1:0]   sub_reg;

    // side fields following the datapath
    logic                        flag_new;
    logic [FW-1:0]               factor_new;
    logic                        mid_flag_reg;
    logic [FW-1:0]               mid_factor_reg;
    logic [hrc_pkg::GATE_W-1:0]  mid_gate_reg;
    logic                        out_flag_reg;
    logic [FW-1:0]               out_factor_reg;
    logic [hrc_pkg::GATE_W-1:0]  out_gate_reg;

    // Configuration writes; indexes outside the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_offset_reg    <= hrc_pkg::RST_HIGH_OFFSET;
            band_width_reg     <= hrc_pkg::RST_BAND_WIDTH;
            ramp_down_step_reg <= hrc_pkg::RST_RAMP_DOWN_STEP;
            ramp_up_step_reg   <= hrc_pkg::RST_RAMP_UP_STEP;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                hrc_pkg::CFG_HIGH_OFFSET: begin
                    high_offset_reg <= cfg_data[hrc_pkg::OFFSET_W-1:0];
                end
                hrc_pkg::CFG_BAND_WIDTH: begin
                    band_width_reg <= cfg_data[hrc_pkg::OFFSET_W-1:0];
                end
                hrc_pkg::CFG_RAMP_DOWN_STEP: begin
                    ramp_down_step_reg <= cfg_data[hrc_pkg::STEP_W-1:0];
                end
                hrc_pkg::CFG_RAMP_UP_STEP: begin
                    ramp_up_step_reg <= cfg_data[hrc_pkg::STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Whole pipeline advances unless a result is held on the output
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_valid;
            mid_valid_reg <= in_valid_reg;
            out_valid_reg <= mid_valid_reg;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            sample_reg <= s_sample;
            base_reg   <= s_threshold_base;
            gate_reg   <= s_gate_byte;
            term_a_reg <= s_term_a;
            term_b_reg <= s_term_b;
            term_c_reg <= s_term_c;
            target_reg <= s_target_term;
            add_reg    <= s_add_term;
            sub_reg    <= s_sub_term;
        end
    end

    // Flag and factor; state moves only with a real transaction
    hrc_ramp #(
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_ramp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .update         (en && in_valid_reg),
        .sample         (sample_reg),
        .threshold_base (base_reg),
        .gate_byte      (gate_reg),
        .high_offset    (high_offset_reg),
        .band_width     (band_width_reg),
        .ramp_down_step (ramp_down_step_reg),
        .ramp_up_step   (ramp_up_step_reg),
        .flag_new       (flag_new),
        .factor_new     (factor_new)
    );

    // Blend datapath
    hrc_blend #(
        .VALUE_WIDTH      (VALUE_WIDTH),
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_blend (
        .aclk        (aclk),
        .en          (en),
        .factor      (factor_new),
        .term_a      (term_a_reg),
        .term_b      (term_b_reg),
        .term_c      (term_c_reg),
        .target_term (target_reg),
        .add_term    (add_reg),
        .sub_term    (sub_reg),
        .result      (m_blended_value)
    );

    // Side fields delayed alongside the datapath
    always_ff @(posedge aclk) begin
        if (en) begin
            mid_flag_reg   <= flag_new;
            mid_factor_reg <= factor_new;
            mid_gate_reg   <= gate_reg;
            out_flag_reg   <= mid_flag_reg;
            out_factor_reg <= mid_factor_reg;
            out_gate_reg   <= mid_gate_reg;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_blend_factor_out = out_factor_reg;
    assign m_hysteresis_flag  = out_flag_reg;
    assign m_gate_echo        = out_gate_reg;

    // Factor never leaves [0, 1.0]
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_blend_factor_out <= FACTOR_ONE))
        else $error("blend factor above 1.0");

    // A stalled pipeline keeps its middle transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mid_valid_reg && !en) |=> mid_valid_reg)
        else $error("transaction lost in stalled pipeline");

    // No result straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

@@ design/hrc_ramp.sv @@
// ----------------------------------------------------------------------------
// hrc_ramp
// Hysteresis flag and ramped blend factor. Holds both as state and returns
// the updated values for the transaction currently in the input register.
// ----------------------------------------------------------------------------
module hrc_ramp #(
    parameter int FACTOR_FRAC_BITS = hrc_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               update,
    input  logic signed [hrc_pkg::IN_W-1:0]    sample,
    input  logic signed [hrc_pkg::IN_W-1:0]    threshold_base,
    input  logic        [hrc_pkg::GATE_W-1:0]  gate_byte,
    input  logic        [hrc_pkg::OFFSET_W-1:0] high_offset,
    input  logic        [hrc_pkg::OFFSET_W-1:0] band_width,
    input  logic        [hrc_pkg::STEP_W-1:0]  ramp_down_step,
    input  logic        [hrc_pkg::STEP_W-1:0]  ramp_up_step,
    output logic                               flag_new,
    output logic        [FACTOR_FRAC_BITS:0]   factor_new
);

    localparam int FW    = FACTOR_FRAC_BITS + 1;
    localparam int SW    = ((FW > hrc_pkg::STEP_W) ? FW : hrc_pkg::STEP_W) + 2;
    localparam int UPR_W = hrc_pkg::IN_W + 2;
    localparam int LWR_W = hrc_pkg::IN_W + 3;
    localparam logic [FW-1:0]        ONE     = FW'(1) << FACTOR_FRAC_BITS;
    localparam logic signed [SW-1:0] ONE_EXT = SW'(1) <<< FACTOR_FRAC_BITS;

    logic                     flag_reg;
    logic [FW-1:0]            factor_reg;
    logic signed [UPR_W-1:0]  upper;
    logic signed [LWR_W-1:0]  lower;
    logic signed [SW-1:0]     f_ext;
    logic signed [SW-1:0]     f_down;
    logic signed [SW-1:0]     f_up;
    logic                     ramp_down;

    // Trip levels, exact
    assign upper = UPR_W'(threshold_base) + UPR_W'($signed({1'b0, high_offset}));
    assign lower = LWR_W'(upper) - LWR_W'($signed({1'b0, band_width}));

    // Hysteresis: set at or above upper, clear below lower, else hold
    always_comb begin
        if (LWR_W'(sample) >= LWR_W'(upper)) begin
            flag_new = 1'b1;
        end else if (LWR_W'(sample) < lower) begin
            flag_new = 1'b0;
        end else begin
            flag_new = flag_reg;
        end
    end

    // Factor ramp with floor at zero and cap at one
    assign ramp_down = (gate_byte == hrc_pkg::GATE_RAMP_DOWN) && !flag_new;
    assign f_ext     = SW'($signed({1'b0, factor_reg}));
    assign f_down    = f_ext - SW'($signed({1'b0, ramp_down_step}));
    assign f_up      = f_ext + SW'($signed({1'b0, ramp_up_step}));

    always_comb begin
        if (ramp_down) begin
            factor_new = (f_down < 0) ? '0 : f_down[FW-1:0];
        end else begin
            factor_new = (f_up > ONE_EXT) ? ONE : f_up[FW-1:0];
        end
    end

    // State
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg   <= 1'b0;
            factor_reg <= '0;
        end else if (update) begin
            flag_reg   <= flag_new;
            factor_reg <= factor_new;
        end
    end

endmodule

@@ design/hrc_blend.sv @@
// ----------------------------------------------------------------------------
// hrc_blend
// Two-stage blend datapath: products registered, then sum, round to
// nearest (ties up) and saturate into the result register.
// ----------------------------------------------------------------------------
module hrc_blend #(
    parameter int VALUE_WIDTH      = hrc_pkg::DEF_VALUE_WIDTH,
    parameter int FACTOR_FRAC_BITS = hrc_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                             aclk,
    input  logic                             en,
    input  logic        [FACTOR_FRAC_BITS:0] factor,
    input  logic signed [hrc_pkg::IN_W-1:0]  term_a,
    input  logic signed [hrc_pkg::IN_W-1:0]  term_b,
    input  logic signed [hrc_pkg::IN_W-1:0]  term_c,
    input  logic signed [hrc_pkg::IN_W-1:0]  target_term,
    input  logic signed [hrc_pkg::IN_W-1:0]  add_term,
    input  logic signed [hrc_pkg::IN_W-1:0]  sub_term,
    output logic signed [VALUE_WIDTH-1:0]    result
);

    localparam int FW    = FACTOR_FRAC_BITS + 1;
    localparam int S_W   = hrc_pkg::IN_W + 2;
    localparam int D_W   = hrc_pkg::IN_W + 1;
    localparam int PT_W  = hrc_pkg::IN_W + FW + 1;
    localparam int PS_W  = S_W + FW + 1;
    localparam int ACC_W = PS_W + 2;
    localparam int CMP_W = (ACC_W > VALUE_WIDTH) ? ACC_W : VALUE_WIDTH + 1;
    localparam logic [FW-1:0]           ONE  = FW'(1) << FACTOR_FRAC_BITS;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FACTOR_FRAC_BITS - 1);
    localparam logic signed [CMP_W-1:0] VMAX =
        {{(CMP_W - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [CMP_W-1:0] VMIN =
        {{(CMP_W - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

    logic signed [S_W-1:0]   sum3;
    logic signed [D_W-1:0]   diff;
    logic        [FW-1:0]    weight;
    logic signed [PT_W-1:0]  pt_next;
    logic signed [PS_W-1:0]  ps_next;
    logic signed [PT_W-1:0]  pt_reg;
    logic signed [PS_W-1:0]  ps_reg;
    logic signed [D_W-1:0]   diff_reg;
    logic signed [ACC_W-1:0] acc;
    logic signed [CMP_W-1:0] rounded;
    logic signed [VALUE_WIDTH-1:0] result_next;
    logic signed [VALUE_WIDTH-1:0] result_reg;

    // Stage 1: operand sums and the two weighted products
    assign sum3    = S_W'(term_a) + S_W'(term_b) + S_W'(term_c);
    assign diff    = D_W'(add_term) - D_W'(sub_term);
    assign weight  = ONE - factor;
    assign pt_next = PT_W'(target_term) * PT_W'($signed({1'b0, factor}));
    assign ps_next = PS_W'(sum3) * PS_W'($signed({1'b0, weight}));

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_reg   <= pt_next;
            ps_reg   <= ps_next;
            diff_reg <= diff;
        end
    end

    // Stage 2: accumulate, round half up, saturate
    assign acc = ACC_W'(pt_reg) + ACC_W'(ps_reg)
               + (ACC_W'(diff_reg) <<< FACTOR_FRAC_BITS) + HALF;
    assign rounded = CMP_W'(acc) >>> FACTOR_FRAC_BITS;

    always_comb begin
        if (rounded > VMAX) begin
            result_next = VMAX[VALUE_WIDTH-1:0];
        end else if (rounded < VMIN) begin
            result_next = VMIN[VALUE_WIDTH-1:0];
        end else begin
            result_next = rounded[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule
